// ----- rtl/core/tsrr_pkg.sv -----
`timescale 1ns / 1ps

package tsrr_pkg;

    // thread pool geometry
    localparam int POOL_SIZE = 32;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);

    // beat field widths
    localparam int OP_W     = 2;
    localparam int TGT_W    = 8;
    localparam int STATUS_W = 2;
    localparam int ID_W     = 5;

    localparam int IN_BITS     = OP_W + TGT_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = STATUS_W + ID_W + 1 + ID_W + ID_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE   = 2'd0,
        OP_SCHEDULE = 2'd1,
        OP_EXIT     = 2'd2,
        OP_KILL     = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE        = 2'd0,
        ST_FULL        = 2'd1,
        ST_BAD_TARGET  = 2'd2,
        ST_QUEUE_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SLOT_EMPTY   = 2'd0,
        SLOT_RUNNING = 2'd1,
        SLOT_ZOMBIE  = 2'd2
    } slot_code_t;

    // single access port into the slot state table
    typedef struct packed {
        logic [IDX_W-1:0] addr;
        logic             we;
        slot_code_t       wdata;
    } slot_req_t;

    function automatic logic [ID_W-1:0] to_id(input logic [IDX_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[ID_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        if (p == IDX_W'(POOL_SIZE - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + IDX_W'(1);
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/tsrr_ram.sv -----
`timescale 1ns / 1ps

module tsrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/tsrr_slot_table.sv -----
`timescale 1ns / 1ps

module tsrr_slot_table (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tsrr_pkg::slot_req_t    req,
    output tsrr_pkg::slot_code_t   rdata
);

    import tsrr_pkg::*;

    slot_code_t slot_reg  [POOL_SIZE];
    slot_code_t slot_next [POOL_SIZE];

    always_comb
    begin
        slot_next = slot_reg;
        if (req.we)
        begin
            slot_next[req.addr] = req.wdata;
        end
    end

    assign rdata = slot_reg[req.addr];

    // slot 0 is the idle thread and comes out of reset running
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                slot_reg[i] <= (i == 0) ? SLOT_RUNNING : SLOT_EMPTY;
            end
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

// ----- rtl/core/tsrr_ctrl.sv -----
`timescale 1ns / 1ps

module tsrr_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    // command side
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tsrr_pkg::op_t                 operation,
    input  logic [tsrr_pkg::TGT_W-1:0]    target_thread,
    // result side
    output logic                          out_valid,
    input  logic                          out_ready,
    output tsrr_pkg::status_t             status,
    output logic [tsrr_pkg::ID_W-1:0]     created_thread,
    output logic                          switched,
    output logic [tsrr_pkg::ID_W-1:0]     previous_thread,
    output logic [tsrr_pkg::ID_W-1:0]     running_thread,
    // slot table port
    output tsrr_pkg::slot_req_t           slot_req,
    input  tsrr_pkg::slot_code_t          slot_rdata,
    // run queue ram
    output logic                          ram_we,
    output logic [tsrr_pkg::IDX_W-1:0]    ram_waddr,
    output logic [tsrr_pkg::IDX_W-1:0]    ram_wdata,
    output logic                          ram_re,
    output logic [tsrr_pkg::IDX_W-1:0]    ram_raddr,
    input  logic [tsrr_pkg::IDX_W-1:0]    ram_rdata
);

    import tsrr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXIT,
        S_SCHED,
        S_POP,
        S_KILL,
        S_FINISH
    } state_t;

    state_t            state_reg,        state_next;
    logic [TGT_W-1:0]  tgt_reg,          tgt_next;
    logic [IDX_W-1:0]  idx_reg,          idx_next;
    logic [IDX_W-1:0]  cur_reg,          cur_next;
    logic [IDX_W-1:0]  prev_reg,         prev_next;
    logic [IDX_W-1:0]  head_reg,         head_next;
    logic [IDX_W-1:0]  tail_reg,         tail_next;
    logic [CNT_W-1:0]  count_reg,        count_next;
    logic              requeue_reg,      requeue_next;
    status_t           status_reg,       status_next;
    logic [ID_W-1:0]   created_reg,      created_next;
    logic              sw_reg,           sw_next;
    logic              out_valid_reg,    out_valid_next;
    status_t           out_status_reg,   out_status_next;
    logic [ID_W-1:0]   out_created_reg,  out_created_next;
    logic              out_sw_reg,       out_sw_next;
    logic [ID_W-1:0]   out_prev_reg,     out_prev_next;
    logic [ID_W-1:0]   out_run_reg,      out_run_next;

    logic [31:0]       tgt_wide;
    logic              room;

    assign tgt_wide = 32'(tgt_reg);
    assign room     = (count_reg < CNT_W'(POOL_SIZE));

    always_comb
    begin
        state_next       = state_reg;
        tgt_next         = tgt_reg;
        idx_next         = idx_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        requeue_next     = requeue_reg;
        status_next      = status_reg;
        created_next     = created_reg;
        sw_next          = sw_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_created_next = out_created_reg;
        out_sw_next      = out_sw_reg;
        out_prev_next    = out_prev_reg;
        out_run_next     = out_run_reg;

        slot_req.addr  = cur_reg;
        slot_req.we    = 1'b0;
        slot_req.wdata = SLOT_ZOMBIE;
        ram_we    = 1'b0;
        ram_waddr = tail_reg;
        ram_wdata = cur_reg;
        ram_re    = 1'b0;
        ram_raddr = head_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    tgt_next     = target_thread;
                    prev_next    = cur_reg;
                    idx_next     = '0;
                    status_next  = ST_DONE;
                    created_next = '0;
                    sw_next      = 1'b0;
                    unique case (operation)
                        OP_CREATE:   state_next = S_SCAN;
                        OP_SCHEDULE: state_next = S_SCHED;
                        OP_EXIT:     state_next = S_EXIT;
                        OP_KILL:     state_next = S_KILL;
                    endcase
                end
            end

            // one slot compared per cycle, lowest empty one wins
            S_SCAN:
            begin
                slot_req.addr = idx_reg;
                if (slot_rdata == SLOT_EMPTY)
                begin
                    slot_req.we    = 1'b1;
                    slot_req.wdata = SLOT_RUNNING;
                    if (room)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = tail_reg;
                        ram_wdata  = idx_reg;
                        tail_next  = ring_next(tail_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                    created_next = to_id(idx_reg);
                    status_next  = ST_DONE;
                    state_next   = S_FINISH;
                end
                else if (idx_reg == IDX_W'(POOL_SIZE - 1))
                begin
                    status_next = ST_FULL;
                    state_next  = S_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_EXIT:
            begin
                slot_req.we    = 1'b1;
                slot_req.wdata = SLOT_ZOMBIE;
                state_next     = S_SCHED;
            end

            S_SCHED:
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_QUEUE_EMPTY;
                    state_next  = S_FINISH;
                end
                else
                begin
                    ram_re       = 1'b1;
                    requeue_next = (slot_rdata == SLOT_RUNNING) && (cur_reg != '0);
                    head_next    = ring_next(head_reg);
                    count_next   = count_reg - CNT_W'(1);
                    state_next   = S_POP;
                end
            end

            // popped id is back from the ram
            S_POP:
            begin
                if (requeue_reg && room)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = tail_reg;
                    ram_wdata  = cur_reg;
                    tail_next  = ring_next(tail_reg);
                    count_next = count_reg + CNT_W'(1);
                end
                sw_next    = (ram_rdata != cur_reg);
                cur_next   = ram_rdata;
                state_next = S_FINISH;
            end

            S_KILL:
            begin
                if ({1'b0, tgt_reg} >= (TGT_W + 1)'(POOL_SIZE))
                begin
                    status_next = ST_BAD_TARGET;
                end
                else
                begin
                    slot_req.addr  = tgt_wide[IDX_W-1:0];
                    slot_req.we    = 1'b1;
                    slot_req.wdata = SLOT_ZOMBIE;
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = status_reg;
                    out_created_next = created_reg;
                    out_sw_next      = sw_reg;
                    out_prev_next    = to_id(prev_reg);
                    out_run_next     = to_id(cur_reg);
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            tgt_reg         <= '0;
            idx_reg         <= '0;
            cur_reg         <= '0;
            prev_reg        <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            requeue_reg     <= 1'b0;
            status_reg      <= ST_DONE;
            created_reg     <= '0;
            sw_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_DONE;
            out_created_reg <= '0;
            out_sw_reg      <= 1'b0;
            out_prev_reg    <= '0;
            out_run_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            tgt_reg         <= tgt_next;
            idx_reg         <= idx_next;
            cur_reg         <= cur_next;
            prev_reg        <= prev_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            requeue_reg     <= requeue_next;
            status_reg      <= status_next;
            created_reg     <= created_next;
            sw_reg          <= sw_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_created_reg <= out_created_next;
            out_sw_reg      <= out_sw_next;
            out_prev_reg    <= out_prev_next;
            out_run_reg     <= out_run_next;
        end
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign created_thread  = out_created_reg;
    assign switched        = out_sw_reg;
    assign previous_thread = out_prev_reg;
    assign running_thread  = out_run_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(POOL_SIZE))
        else $error("run queue count above pool size");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (count_reg != '0))
        else $error("pop from empty run queue");

    a_pop_follows_sched: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCHED) && (count_reg != '0) |=> (state_reg == S_POP))
        else $error("queue pop not followed by data capture");

    a_empty_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) && (status_reg == ST_QUEUE_EMPTY) |-> !sw_reg)
        else $error("switch reported with empty run queue");

endmodule

// ----- rtl/core/thread_slot_round_robin_scheduler.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   operation, target_thread
// m_axis    out  m_axis_tvalid/m_axis_tready   status, created_thread, switched,
//                                              previous_thread, running_thread
//
// one command beat at a time; s_axis_tready is high only while the sequencer idles
// create: the slot table is scanned one slot per cycle, lowest empty slot first
// schedule pops the registered queue ram read; exit marks the current slot zombie first
// a finished result waits in the output register; a stalled m_axis holds the sequencer
// rst_n (async, active low) sets slot 0 running and current, queue empty; no clear pass

module thread_slot_round_robin_scheduler (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] operation, [9:2] target_thread, rest zero
    input  logic [tsrr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] status, [6:2] created_thread, [7] switched,
    // [12:8] previous_thread, [17:13] running_thread, rest zero
    output logic [tsrr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    import tsrr_pkg::*;

    op_t               operation;
    logic [TGT_W-1:0]  target_thread;
    status_t           status;
    logic [ID_W-1:0]   created_thread;
    logic              switched;
    logic [ID_W-1:0]   previous_thread;
    logic [ID_W-1:0]   running_thread;

    slot_req_t         slot_req;
    slot_code_t        slot_rdata;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [IDX_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [IDX_W-1:0]  ram_rdata;

    // unpack the command beat
    assign operation     = op_t'(s_axis_tdata[OP_W-1:0]);
    assign target_thread = s_axis_tdata[OP_W +: TGT_W];

    // pack the result beat, zero fill to a whole byte
    assign m_axis_tdata = OUT_TDATA_W'({running_thread, previous_thread, switched,
                                        created_thread, status});

    tsrr_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .operation       (operation),
        .target_thread   (target_thread),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .status          (status),
        .created_thread  (created_thread),
        .switched        (switched),
        .previous_thread (previous_thread),
        .running_thread  (running_thread),
        .slot_req        (slot_req),
        .slot_rdata      (slot_rdata),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_re          (ram_re),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata)
    );

    // per-slot empty / running / zombie state
    tsrr_slot_table u_slots (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (slot_req),
        .rdata (slot_rdata)
    );

    // run queue storage, ring addressed by head and tail
    tsrr_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_SIZE)
    ) u_run_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
